[hw/rtl/lprf_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// lprf_pkg
// Shared constants, result codes and controller/datapath link types for the
// length-prefixed record FIFO.
// -----------------------------------------------------------------------------
package lprf_pkg;

	localparam int DEPTH_DEF  = 512;
	localparam int MAX_RECORD = 64;
	localparam int LEN_W      = 7;
	localparam int BYTE_W     = 8;
	localparam int HDR_BYTES  = 2;

	// Function codes of an input word
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef enum logic [1:0] {
		STAT_POPPED   = 2'd0,
		STAT_STORED   = 2'd1,
		STAT_REJECTED = 2'd2,
		STAT_EMPTY    = 2'd3
	} status_t;

	// Controller to datapath: one step per state
	typedef struct packed {
		logic load;
		logic push_head;
		logic push_step;
		logic pop_head;
		logic pop_len;
		logic pop_step;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic last_beat;
	} dp_stat_t;

endpackage
`default_nettype wire

[hw/rtl/lprf_ram.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// lprf_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module lprf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

[hw/rtl/lprf_ctrl.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// lprf_ctrl
// Sequencer: steps a push word through header and byte writes, and a pop word
// through header read and byte streaming.
// -----------------------------------------------------------------------------
module lprf_ctrl import lprf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     func,
	input  dp_stat_t stat,
	output logic     busy,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH_HEAD,
		S_PUSH_BYTE,
		S_POP_HEAD,
		S_POP_LEN,
		S_POP_STREAM
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (func == FUNC_POP) ? S_POP_HEAD : S_PUSH_HEAD;
						busy_q  <= 1'b1;
					end
				end
				S_PUSH_HEAD: begin
					state_q <= S_PUSH_BYTE;
				end
				S_PUSH_BYTE: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				S_POP_HEAD: begin
					if (stat.empty) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_POP_LEN;
					end
				end
				S_POP_LEN: begin
					state_q <= S_POP_STREAM;
				end
				S_POP_STREAM: begin
					if (stat.last_beat) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && accept;
		cmd.push_head = (state_q == S_PUSH_HEAD);
		cmd.push_step = (state_q == S_PUSH_BYTE);
		cmd.pop_head  = (state_q == S_POP_HEAD);
		cmd.pop_len   = (state_q == S_POP_LEN);
		cmd.pop_step  = (state_q == S_POP_STREAM);
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

[hw/rtl/lprf_dp.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// lprf_dp
// Datapath: ring pointers, space check, record bookkeeping, byte store and
// result registers.
// -----------------------------------------------------------------------------
module lprf_dp import lprf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          cmd,
	input  logic              first_of_record,
	input  logic [LEN_W-1:0]  record_length,
	input  logic [BYTE_W-1:0] push_byte,
	output dp_stat_t          stat,
	output logic              strobe,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] pop_byte,
	output logic              last_byte
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int NMAX = (1 << LEN_W) - 1 + HDR_BYTES;
	localparam int SW   = $clog2(DEPTH + NMAX + 1);

	// Latched word
	logic              first_q;
	logic [LEN_W-1:0]  len_q;
	logic [BYTE_W-1:0] byte_q;

	// Ring and record state
	logic [AW-1:0]     front_q;
	logic [AW-1:0]     tail_q;
	logic [AW-1:0]     used_q;
	logic [AW-1:0]     wpoint_q;
	logic              wpend_q;
	logic [CW-1:0]     windex_q;
	logic [LEN_W-1:0]  left_q;
	logic              rej_q;
	logic [LEN_W:0]    rec_n_q;
	logic              rec_wrap_q;

	// Pop streaming
	logic [LEN_W-1:0]  pop_len_q;
	logic [LEN_W-1:0]  rem_q;
	logic [AW-1:0]     rd_ptr_q;

	// Result registers
	logic              strobe_q;
	status_t           status_q;
	logic [BYTE_W-1:0] pop_byte_q;
	logic              last_q;

	// RAM port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	// Space check
	logic [SW-1:0]     n_s;
	logic [SW-1:0]     tail_end_s;
	logic              len_bad;
	logic              hd_ok;
	logic              hd_wrap;
	logic [AW-1:0]     hd_start;

	// Commit
	logic [CW-1:0]     wsum;
	logic [AW-1:0]     tail_new;
	logic [AW-1:0]     used_add;

	// Pop
	logic              hit_head;
	logic [AW-1:0]     front_chk;
	logic [LEN_W-1:0]  rl;
	logic [SW-1:0]     fsum_s;
	logic [SW-1:0]     fnext_s;
	logic [AW-1:0]     fnext;
	logic              hit_tail;
	logic [SW-1:0]     npop_s;
	logic [AW-1:0]     used_sub;
	logic              rec_open;

	// Emit
	logic              push_done;
	logic              emit_v;
	status_t           emit_status;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_last;

	assign n_s        = SW'(len_q) + SW'(HDR_BYTES);
	assign tail_end_s = SW'(tail_q) + n_s;
	assign len_bad    = (len_q == '0) || (len_q > LEN_W'(MAX_RECORD));

	always_comb begin
		hd_ok   = 1'b0;
		hd_wrap = 1'b0;
		if (len_bad || (SW'(used_q) + n_s >= SW'(DEPTH))) begin
			hd_ok = 1'b0;
		end else if ((used_q != '0) && (tail_q <= front_q)) begin
			hd_ok = (tail_end_s <= SW'(front_q));
		end else if (tail_end_s <= SW'(DEPTH)) begin
			hd_ok = 1'b1;
		end else if (n_s < SW'(front_q)) begin
			hd_ok   = 1'b1;
			hd_wrap = 1'b1;
		end
	end

	assign hd_start = hd_wrap ? '0 : tail_q;

	assign wsum     = windex_q + CW'(1);
	assign tail_new = (wsum == CW'(DEPTH)) ? '0 : wsum[AW-1:0];
	assign used_add = AW'(SW'(used_q) + SW'(rec_n_q));

	assign hit_head  = wpend_q && (front_q == wpoint_q);
	assign front_chk = hit_head ? '0 : front_q;

	// Clamp the header length into the legal record range
	always_comb begin
		if (ram_rdata == '0) begin
			rl = LEN_W'(1);
		end else if (ram_rdata > BYTE_W'(MAX_RECORD)) begin
			rl = LEN_W'(MAX_RECORD);
		end else begin
			rl = ram_rdata[LEN_W-1:0];
		end
	end

	assign npop_s   = SW'(pop_len_q) + SW'(HDR_BYTES);
	assign fsum_s   = SW'(front_q) + npop_s;
	assign fnext_s  = (fsum_s >= SW'(DEPTH)) ? (fsum_s - SW'(DEPTH)) : fsum_s;
	assign fnext    = fnext_s[AW-1:0];
	assign hit_tail = wpend_q && (fnext == wpoint_q);
	assign used_sub = (npop_s >= SW'(used_q)) ? '0 : AW'(SW'(used_q) - npop_s);
	assign rec_open = (left_q != '0) && !rej_q;

	// RAM access
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hd_start;
		ram_wdata = BYTE_W'(len_q);
		if (cmd.push_head) begin
			ram_we = first_q && hd_ok;
		end else if (cmd.push_step) begin
			ram_we    = (left_q != '0) && !rej_q;
			ram_waddr = windex_q[AW-1:0];
			ram_wdata = byte_q;
		end
	end

	always_comb begin
		ram_raddr = rd_ptr_q;
		if (cmd.pop_head) begin
			ram_raddr = front_chk;
		end else if (cmd.pop_len) begin
			ram_raddr = front_q + AW'(HDR_BYTES);
		end
	end

	lprf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Result selection
	assign push_done = cmd.push_step && (left_q == LEN_W'(1));

	always_comb begin
		emit_v      = 1'b0;
		emit_status = STAT_POPPED;
		emit_byte   = '0;
		emit_last   = 1'b1;
		if (push_done) begin
			emit_v      = 1'b1;
			emit_status = rej_q ? STAT_REJECTED : STAT_STORED;
		end else if (cmd.pop_head && (used_q == '0)) begin
			emit_v      = 1'b1;
			emit_status = STAT_EMPTY;
		end else if (cmd.pop_step) begin
			emit_v    = 1'b1;
			emit_byte = ram_rdata;
			emit_last = (rem_q == LEN_W'(1));
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 1'b0;
			front_q    <= '0;
			tail_q     <= '0;
			used_q     <= '0;
			wpoint_q   <= '0;
			wpend_q    <= 1'b0;
			windex_q   <= '0;
			left_q     <= '0;
			rej_q      <= 1'b0;
			rec_n_q    <= '0;
			rec_wrap_q <= 1'b0;
			rem_q      <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= emit_v;
			if (cmd.load) begin
				first_q <= first_of_record;
			end
			// Open a record: run the space check and claim the header slot
			if (cmd.push_head && first_q) begin
				left_q     <= (len_q == '0) ? LEN_W'(1) : len_q;
				rej_q      <= !hd_ok;
				rec_n_q    <= (LEN_W + 1)'(len_q) + (LEN_W + 1)'(HDR_BYTES);
				rec_wrap_q <= hd_wrap;
				if (hd_ok) begin
					windex_q <= CW'(hd_start) + CW'(HDR_BYTES);
				end
			end
			// Take one payload byte; drop it for a rejected record
			if (cmd.push_step && (left_q != '0)) begin
				left_q <= left_q - LEN_W'(1);
				if (!rej_q) begin
					windex_q <= wsum;
				end
				if (left_q == LEN_W'(1)) begin
					if (rej_q) begin
						rej_q <= 1'b0;
					end else begin
						if (rec_wrap_q) begin
							wpoint_q <= tail_q;
							wpend_q  <= 1'b1;
						end
						tail_q   <= tail_new;
						windex_q <= CW'(tail_new);
						used_q   <= used_add;
					end
				end
			end
			if (cmd.pop_head && (used_q != '0) && hit_head) begin
				front_q <= '0;
				wpend_q <= 1'b0;
			end
			if (cmd.pop_len) begin
				rem_q <= rl;
			end
			if (cmd.pop_step) begin
				rem_q <= rem_q - LEN_W'(1);
				// Retire the record after its last byte
				if (rem_q == LEN_W'(1)) begin
					front_q <= hit_tail ? '0 : fnext;
					if (hit_tail) begin
						wpend_q <= 1'b0;
					end
					used_q <= used_sub;
					if ((used_sub == '0) && !rec_open) begin
						front_q  <= '0;
						tail_q   <= '0;
						windex_q <= '0;
						wpend_q  <= 1'b0;
					end
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q  <= record_length;
			byte_q <= push_byte;
		end
		if (cmd.pop_len) begin
			pop_len_q <= rl;
			rd_ptr_q  <= front_q + AW'(HDR_BYTES + 1);
		end
		if (cmd.pop_step) begin
			rd_ptr_q <= rd_ptr_q + AW'(1);
		end
		if (emit_v) begin
			status_q   <= emit_status;
			pop_byte_q <= emit_byte;
			last_q     <= emit_last;
		end
	end

	assign stat.empty     = (used_q == '0);
	assign stat.last_beat = (rem_q == LEN_W'(1));

	assign strobe    = strobe_q;
	assign status    = status_q;
	assign pop_byte  = pop_byte_q;
	assign last_byte = last_q;

endmodule
`default_nettype wire

[hw/rtl/length_prefixed_record_fifo_top.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// length_prefixed_record_fifo_top
// Byte ring store of variable-length records, each behind a 2-byte length
// header; push one payload byte per word, pop streams the oldest record.
// -----------------------------------------------------------------------------
//
// Channel   Handshake            Fields
// -------   ------------------   ------------------------------------------------
// command   start / busy         func, first_of_record, record_length, push_byte
// result    strobe (no stall)    status, pop_byte, last_byte
//
// A command word is taken at a rising edge with start high and busy low.
// Push word: busy through a header write, then a payload write, both through
//   the single RAM write port; a record's status shows on its last byte.
// Pop word: a header read alone when empty; otherwise header read, length
//   decode, then one byte per cycle off the RAM read port.
// Each result sits on the result ports for one cycle under strobe, in the
//   cycle after the step that makes it; the receiver cannot stall, so nothing waits.
// Reset clears pointers, counts and flags at once; the byte store is not
//   cleared, so there is no clearing pass after reset.
//
module length_prefixed_record_fifo_top import lprf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic              first_of_record,
	input  logic [LEN_W-1:0]  record_length,
	input  logic [BYTE_W-1:0] push_byte,
	output logic              strobe,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] pop_byte,
	output logic              last_byte
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Sequencer: one state per step of a word
	lprf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Pointers, space check, byte store and result registers
	lprf_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.first_of_record (first_of_record),
		.record_length   (record_length),
		.push_byte       (push_byte),
		.stat            (stat),
		.strobe          (strobe),
		.status          (status),
		.pop_byte        (pop_byte),
		.last_byte       (last_byte)
	);

`ifndef ASSERT_OFF
	// A popped record streams without gaps until its last byte
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_byte |=> strobe)
		else $error("pop stream broke before last byte");

	// Only popped bytes may come without the last mark
	a_single_status: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != STAT_POPPED) |-> last_byte)
		else $error("status result without last mark");

	// A taken word holds off the next one
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");
`endif

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed record FIFO. A scoreboard class
// keeps its own copy of the ring store, pointers and open-record bookkeeping,
// predicts every status and popped byte for each accepted command word, and
// compares the strobed results in order. Stimulus is a short directed list,
// then a fill phase that pushes the store close to full, a churn phase that
// keeps it near full so records wrap to address 0 or are refused, and a drain
// phase.
// -----------------------------------------------------------------------------
module testbench;
	import lprf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// Scoreboard: predicts results per accepted word and checks them in order
	class record_scoreboard;
		typedef struct {
			status_t           code;
			logic [BYTE_W-1:0] data;
			logic              last;
		} fifo_result_t;

		fifo_result_t      awaited[$];
		logic [BYTE_W-1:0] ring [DEPTH_DEF];
		int unsigned       front, tail, used, wrap_at, wr_ptr;
		int unsigned       left_in_record, open_length;
		bit                wrap_armed, dropping;
		int                errors, n_stored, n_rejected, n_empty, n_popped;
		int                n_wraps, n_abandoned;

		function new();
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function void await_result(status_t code, logic [BYTE_W-1:0] data, logic last);
			awaited.push_back('{code, data, last});
		endfunction

		// Space check on the first byte; place the header at tail or at 0
		function void open_record(int unsigned ln);
			int unsigned n, at;
			bit ok;
			n = ln + HDR_BYTES;
			at = 0;
			ok = 1'b0;
			open_length = ln;
			left_in_record = (ln == 0) ? 1 : ln;
			if (ln == 0 || ln > MAX_RECORD || used + n >= DEPTH_DEF) begin
				ok = 1'b0;
			end else if (used > 0 && tail <= front) begin
				if (tail + n <= front) begin
					ok = 1'b1;
					at = tail;
				end
			end else if (tail + n <= DEPTH_DEF) begin
				ok = 1'b1;
				at = tail;
			end else if (n < front) begin
				ok = 1'b1;
			end
			dropping = !ok;
			if (ok) begin
				ring[at % DEPTH_DEF] = ln[7:0];
				ring[(at + 1) % DEPTH_DEF] = ln[15:8];
				wr_ptr = at + HDR_BYTES;
			end
		endfunction

		// Make the record visible; a start other than tail means it wrapped
		function void seal_record();
			int unsigned n, at;
			n = open_length + HDR_BYTES;
			at = (wr_ptr >= n) ? wr_ptr - n : 0;
			if (at != tail) begin
				wrap_at = tail;
				wrap_armed = 1'b1;
			end
			tail = wr_ptr % DEPTH_DEF;
			wr_ptr = tail;
			used += n;
		endfunction

		function void follow_wrap();
			if (wrap_armed && front == wrap_at) begin
				front = 0;
				wrap_armed = 1'b0;
				n_wraps++;
			end
		endfunction

		function void note_word(logic f, logic fst, logic [LEN_W-1:0] ln,
				logic [BYTE_W-1:0] b);
			int unsigned rl, n;
			if (f == FUNC_PUSH) begin
				if (fst) begin
					if (left_in_record != 0) n_abandoned++;
					open_record(ln);
				end else if (left_in_record == 0) begin
					return;
				end
				if (!dropping) begin
					ring[wr_ptr % DEPTH_DEF] = b;
					wr_ptr++;
				end
				left_in_record--;
				if (left_in_record != 0) return;
				if (dropping) begin
					dropping = 1'b0;
					n_rejected++;
					await_result(STAT_REJECTED, '0, 1'b1);
				end else begin
					seal_record();
					n_stored++;
					await_result(STAT_STORED, '0, 1'b1);
				end
				return;
			end
			if (used == 0) begin
				n_empty++;
				await_result(STAT_EMPTY, '0, 1'b1);
				return;
			end
			follow_wrap();
			rl = {ring[(front + 1) % DEPTH_DEF], ring[front % DEPTH_DEF]};
			if (rl < 1) rl = 1;
			if (rl > MAX_RECORD) rl = MAX_RECORD;
			for (int unsigned i = 0; i < rl; i++)
				await_result(STAT_POPPED, ring[(front + HDR_BYTES + i) % DEPTH_DEF],
					(i + 1 == rl));
			n_popped += rl;
			n = rl + HDR_BYTES;
			front = (front + n) % DEPTH_DEF;
			used = (n >= used) ? 0 : used - n;
			follow_wrap();
			if (used == 0 && !(left_in_record != 0 && !dropping)) begin
				front = 0;
				tail = 0;
				wr_ptr = 0;
				wrap_armed = 1'b0;
			end
		endfunction

		function void check_result(logic [1:0] st, logic [BYTE_W-1:0] data, logic last);
			fifo_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: status %0d byte %h last %b",
					$time, st, data, last);
				return;
			end
			want = awaited.pop_front();
			if (st !== want.code) begin
				errors++;
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, want.code, st);
			end
			if (data !== want.data) begin
				errors++;
				$display("%0t: pop_byte mismatch: expected %h, actual %h",
					$time, want.data, data);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: last_byte mismatch: expected %b, actual %b",
					$time, want.last, last);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              func;
	logic              first_of_record;
	logic [LEN_W-1:0]  record_length;
	logic [BYTE_W-1:0] push_byte;
	logic              strobe;
	logic [1:0]        status;
	logic [BYTE_W-1:0] pop_byte;
	logic              last_byte;

	record_scoreboard sb = new();

	int cycle_count = 0;
	int words_sent = 0;
	int bytes_to_go;     // payload bytes still owed to the record being generated
	bit idle_enabled;

	length_prefixed_record_fifo_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.first_of_record (first_of_record),
		.record_length   (record_length),
		.push_byte       (push_byte),
		.strobe          (strobe),
		.status          (status),
		.pop_byte        (pop_byte),
		.last_byte       (last_byte)
	);

	always #10 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Abort a hung run: the slowest legal run is far below this
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d results still awaited", $time, sb.awaited.size());
		$display("DONE: errors detected");
		$finish;
	end

	// Take each strobed result at the edge that ends its cycle; the strobe
	// itself must never be unknown once reset is released
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (strobe === 1'b1) begin
				sb.check_result(status, pop_byte, last_byte);
			end else if (strobe !== 1'b0) begin
				sb.errors++;
				$display("%0t: strobe mismatch: expected 0 or 1, actual %b", $time, strobe);
			end
		end
	end

	// Offer one command word and hold it until an edge sees busy low; then
	// note it for prediction and, when idling is enabled, sometimes drop start
	task automatic send_word(input logic f, input logic fst, input logic [LEN_W-1:0] ln,
			input logic [BYTE_W-1:0] b);
		start           <= 1'b1;
		func            <= f;
		first_of_record <= fst;
		record_length   <= ln;
		push_byte       <= b;
		do @(posedge clk); while (busy);
		sb.note_word(f, fst, ln, b);
		words_sent++;
		if (idle_enabled && $urandom_range(99) < 37) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Stop sending, wait for every awaited result, then let the block finish
	// any push word that produces no result
	task automatic settle(input int hold);
		start <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (hold) @(posedge clk);
	endtask

	// Random words: pops at pop_pct percent, otherwise record bytes that mostly
	// complete well-formed records, with stray bytes, bad lengths and
	// abandoned records mixed in. Stray bytes do not count toward the total.
	task automatic run_phase(input int count, input int pop_pct, input int len_lo,
			input int len_hi, input bit idle_ok);
		int done;
		int r;
		logic [LEN_W-1:0] ln;
		done = 0;
		idle_enabled = idle_ok;
		while (done < count) begin
			if ($urandom_range(99) < pop_pct) begin
				// Push fields are don't-care on a pop; randomize them anyway
				send_word(FUNC_POP, 1'($urandom_range(1)), 7'($urandom_range(127)),
					8'($urandom_range(255)));
				done++;
			end else if (bytes_to_go == 0 && $urandom_range(99) < 4) begin
				send_word(FUNC_PUSH, 1'b0, 7'($urandom_range(127)), 8'($urandom_range(255)));
			end else if (bytes_to_go == 0 || $urandom_range(99) < 2) begin
				r = $urandom_range(99);
				if (r < 2)
					ln = '0;
				else if (r < 4)
					ln = 7'($urandom_range(MAX_RECORD + 1, 127));
				else
					ln = 7'($urandom_range(len_lo, len_hi));
				send_word(FUNC_PUSH, 1'b1, ln, 8'($urandom_range(255)));
				bytes_to_go = (ln == 0) ? 0 : ln - 1;
				done++;
			end else begin
				send_word(FUNC_PUSH, 1'b0, 7'($urandom_range(127)), 8'($urandom_range(255)));
				bytes_to_go--;
				done++;
			end
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		start           <= 1'b0;
		func            <= FUNC_PUSH;
		first_of_record <= 1'b0;
		record_length   <= '0;
		push_byte       <= '0;
		idle_enabled = 1'b1;
		bytes_to_go = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pop on an empty queue
		send_word(FUNC_POP, 1'b1, 7'h7F, 8'hFF);
		// Shortest record, then a two-byte one with extreme byte values
		send_word(FUNC_PUSH, 1'b1, 7'd1, 8'h00);
		send_word(FUNC_PUSH, 1'b1, 7'd2, 8'hFF);
		send_word(FUNC_PUSH, 1'b0, 7'd0, 8'h5A);
		// Stray byte with no record open: no result
		send_word(FUNC_PUSH, 1'b0, 7'd0, 8'h33);
		// Zero length: refused on its only byte
		send_word(FUNC_PUSH, 1'b1, 7'd0, 8'h11);
		// Oversized length opens a refused record; a new first byte drops it
		send_word(FUNC_PUSH, 1'b1, 7'h7F, 8'h22);
		send_word(FUNC_PUSH, 1'b1, 7'd3, 8'h01);
		send_word(FUNC_PUSH, 1'b0, 7'd0, 8'h02);
		send_word(FUNC_PUSH, 1'b0, 7'd0, 8'h03);
		// Accepted record abandoned halfway by a new first byte
		send_word(FUNC_PUSH, 1'b1, 7'd4, 8'hAA);
		send_word(FUNC_PUSH, 1'b0, 7'd0, 8'hBB);
		send_word(FUNC_PUSH, 1'b1, 7'd1, 8'hCC);
		// Pop the first three records
		send_word(FUNC_POP, 1'b0, 7'd0, 8'h00);
		send_word(FUNC_POP, 1'b0, 7'd0, 8'h00);
		send_word(FUNC_POP, 1'b0, 7'd0, 8'h00);
		// Empty the store while a record is open, then finish that record
		send_word(FUNC_PUSH, 1'b1, 7'd5, 8'hD0);
		send_word(FUNC_POP, 1'b0, 7'd0, 8'h00);
		send_word(FUNC_PUSH, 1'b0, 7'd0, 8'hD1);
		send_word(FUNC_PUSH, 1'b0, 7'd0, 8'hD2);
		send_word(FUNC_PUSH, 1'b0, 7'd0, 8'hD3);
		send_word(FUNC_PUSH, 1'b0, 7'd0, 8'hD4);
		send_word(FUNC_POP, 1'b0, 7'd0, 8'h00);
		send_word(FUNC_POP, 1'b0, 7'd0, 8'h00);
		settle(8);

		// Fill: push only, large records, to bring the store close to full
		run_phase(380, 0, 24, 64, 1'b1);
		settle(8);
		// Churn near full so records wrap to address 0; first stretch back to back
		run_phase(40, 2, 1, 64, 1'b0);
		run_phase(40, 2, 1, 64, 1'b1);
		// Drain: mostly pops, short records, empty pops
		run_phase(40, 60, 1, 8, 1'b1);
		settle(20);

		$display("Sent %0d command words: %0d records stored, %0d refused, %0d abandoned",
			words_sent, sb.n_stored, sb.n_rejected, sb.n_abandoned);
		$display("Popped %0d bytes, %0d empty pops, %0d wraps of the read side to address 0",
			sb.n_popped, sb.n_empty, sb.n_wraps);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/lprf_pkg.sv
hw/rtl/lprf_ram.sv
hw/rtl/lprf_ctrl.sv
hw/rtl/lprf_dp.sv
hw/rtl/length_prefixed_record_fifo_top.sv
sim/testbench.sv
